>>> design/ric_pkg.sv
// ric_pkg: shared widths, constants, codes and types of the readability index counter
// no dependencies; every other file of the block but ric_text_if refers to it by scoped names
`default_nettype none

package ric_pkg;

  // tally width; the product and datapath widths follow from it
  localparam int unsigned TALLY_WIDTH = 16;

  // coleman-liau coefficients scaled by 100 for exact integer math
  localparam int unsigned CoefLetter   = 588;
  localparam int unsigned CoefSentence = 2960;
  localparam int unsigned CoefWord     = 1580;
  localparam int unsigned DenScale     = 200;   // 2 * 100 * words
  localparam int unsigned BiasScale    = 100;   // rounding bias 100 * words

  // product and datapath widths
  localparam int unsigned WORDS_W  = TALLY_WIDTH + 1;
  localparam int unsigned PROD_L_W = TALLY_WIDTH + 10;
  localparam int unsigned PROD_E_W = TALLY_WIDTH + 12;
  localparam int unsigned PROD_W_W = TALLY_WIDTH + 11;
  localparam int unsigned BIAS_W   = TALLY_WIDTH + 7;
  localparam int unsigned NUM_W    = TALLY_WIDTH + 14;
  localparam int unsigned DIVD_W   = NUM_W + 1;
  localparam int unsigned DIVR_W   = TALLY_WIDTH + 8;
  localparam int unsigned CNT_W    = $clog2(DIVD_W);

  // result range
  localparam int unsigned INDEX_W      = 22;
  localparam int unsigned IndexHigh    = 400000;
  localparam int unsigned IndexLowMag  = 2000000;
  localparam int unsigned CMP_W        = (DIVD_W > INDEX_W) ? DIVD_W : INDEX_W;
  localparam int unsigned GradeTop     = 16;

  // character codes
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharQuery = 8'h3F;
  localparam logic [7:0] CharBang  = 8'h21;

  typedef logic [TALLY_WIDTH-1:0] tally_t;

  localparam tally_t TallyMax = '1;

  // grade band codes
  typedef enum logic [1:0] {
    BAND_BELOW   = 2'd0,
    BAND_GRADE   = 2'd1,
    BAND_COLLEGE = 2'd2
  } band_e;

  // counts of one finished text
  typedef struct packed {
    tally_t letters;
    tally_t spaces;
    tally_t sentences;
  } snapshot_t;

endpackage

`default_nettype wire

>>> design/ric_text_if.sv
// ric_text_if: valid/ready channel that carries text bytes with a last-byte mark
// no dependencies
`default_nettype none

interface ric_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> design/ric_result_if.sv
// ric_result_if: valid/ready channel that carries the index and grade of one text
// depends on ric_pkg for the index width
`default_nettype none

interface ric_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [ric_pkg::INDEX_W-1:0]  readability_index;
  logic [1:0]                          grade_band;
  logic [3:0]                          grade_number;

  modport source (output valid, output readability_index, output grade_band,
                  output grade_number, input ready);
  modport sink   (input valid, input readability_index, input grade_band,
                  input grade_number, output ready);
endinterface

`default_nettype wire

>>> design/ric_front.sv
// ric_front: classifies text bytes and keeps the saturating tallies
// depends on ric_pkg and ric_text_if; hands a snapshot to the queue on the last byte
`default_nettype none

module ric_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ric_text_if.sink            text_i,
  output ric_pkg::snapshot_t  push_data_o,
  output logic                push_valid_o,
  input  wire logic           push_ready_i
);

  ric_pkg::tally_t letters_q, spaces_q, sentences_q;
  ric_pkg::tally_t letters_d, spaces_d, sentences_d;
  logic is_letter, is_space, is_sentence, accept;

  function automatic ric_pkg::tally_t sat_inc(ric_pkg::tally_t t);
    return (t == ric_pkg::TallyMax) ? t : t + 1'b1;
  endfunction

  always_comb begin
    is_letter   = text_i.text_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    is_space    = (text_i.text_byte == ric_pkg::CharSpace);
    is_sentence = text_i.text_byte inside {ric_pkg::CharDot, ric_pkg::CharQuery,
                                           ric_pkg::CharBang};
    letters_d   = is_letter   ? sat_inc(letters_q)   : letters_q;
    spaces_d    = is_space    ? sat_inc(spaces_q)    : spaces_q;
    sentences_d = is_sentence ? sat_inc(sentences_q) : sentences_q;
  end

  assign text_i.ready = push_ready_i;
  assign accept       = text_i.valid && push_ready_i;
  assign push_valid_o = accept && text_i.end_of_text;
  assign push_data_o  = '{letters: letters_d, spaces: spaces_d, sentences: sentences_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letters_q   <= '0;
      spaces_q    <= '0;
      sentences_q <= '0;
    end else if (accept) begin
      if (text_i.end_of_text) begin
        letters_q   <= '0;
        spaces_q    <= '0;
        sentences_q <= '0;
      end else begin
        letters_q   <= letters_d;
        spaces_q    <= spaces_d;
        sentences_q <= sentences_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ric_queue.sv
// ric_queue: two-entry queue of text snapshots between front and back
// depends on ric_pkg
`default_nettype none

module ric_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ric_pkg::snapshot_t  push_data_i,
  input  wire logic                push_valid_i,
  output logic                     push_ready_o,
  output ric_pkg::snapshot_t       pop_data_o,
  output logic                     pop_valid_o,
  input  wire logic                pop_ready_i
);

  ric_pkg::snapshot_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/ric_back.sv
// ric_back: scales the counts, divides bit-serially, rounds, clamps and grades
// depends on ric_pkg and ric_result_if; owns the result output register
`default_nettype none

module ric_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ric_pkg::snapshot_t  pop_data_i,
  input  wire logic                pop_valid_i,
  output logic                     pop_ready_o,
  ric_result_if.source             result_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                          state_q;
  ric_pkg::snapshot_t              snap_q;
  logic [ric_pkg::PROD_L_W-1:0]    prod_l_q;
  logic [ric_pkg::PROD_E_W-1:0]    prod_e_q;
  logic [ric_pkg::PROD_W_W-1:0]    prod_w_q;
  logic [ric_pkg::BIAS_W-1:0]      bias_q;
  logic [ric_pkg::DIVR_W-1:0]      den_q;
  logic [ric_pkg::NUM_W-1:0]       num_q;
  logic                            neg_q;
  logic [ric_pkg::DIVD_W-1:0]      dvd_q;
  logic [ric_pkg::DIVD_W-1:0]      quo_q;
  logic [ric_pkg::DIVR_W-1:0]      rem_q;
  logic [ric_pkg::CNT_W-1:0]       cnt_q;
  logic                            out_valid_q;
  logic signed [ric_pkg::INDEX_W-1:0] idx_q;
  ric_pkg::band_e                  band_q;
  logic [3:0]                      number_q;

  logic [ric_pkg::WORDS_W-1:0]     words;
  logic [ric_pkg::NUM_W-1:0]       num_d, abs_num;
  logic [ric_pkg::DIVD_W-1:0]      dvd_d;
  logic [ric_pkg::DIVR_W:0]        trial, diff;
  logic                            fits;
  logic [ric_pkg::CMP_W-1:0]       q_ext, limit;
  logic [ric_pkg::INDEX_W-1:0]     mag, idx_d;
  ric_pkg::band_e                  band_d;
  logic [3:0]                      number_d;
  logic                            out_free;

  always_comb begin
    words   = ric_pkg::WORDS_W'(snap_q.spaces) + 1'b1;
    num_d   = ric_pkg::NUM_W'(prod_l_q) - ric_pkg::NUM_W'(prod_e_q)
            - ric_pkg::NUM_W'(prod_w_q);
    abs_num = neg_q ? (~num_q + 1'b1) : num_q;
    dvd_d   = {abs_num, 1'b0} + ric_pkg::DIVD_W'(bias_q);
    // restoring division step
    trial   = {rem_q, dvd_q[ric_pkg::DIVD_W-1]};
    fits    = (trial >= {1'b0, den_q});
    diff    = trial - {1'b0, den_q};
    // clamp and grade
    q_ext   = ric_pkg::CMP_W'(quo_q);
    limit   = neg_q ? ric_pkg::CMP_W'(ric_pkg::IndexLowMag)
                    : ric_pkg::CMP_W'(ric_pkg::IndexHigh);
    mag     = (q_ext > limit) ? ric_pkg::INDEX_W'(limit) : ric_pkg::INDEX_W'(q_ext);
    idx_d   = neg_q ? (~mag + 1'b1) : mag;
    if (neg_q || (mag == '0)) begin
      band_d   = ric_pkg::BAND_BELOW;
      number_d = 4'd0;
    end else if (mag >= ric_pkg::INDEX_W'(ric_pkg::GradeTop)) begin
      band_d   = ric_pkg::BAND_COLLEGE;
      number_d = 4'd0;
    end else begin
      band_d   = ric_pkg::BAND_GRADE;
      number_d = mag[3:0];
    end
  end

  assign pop_ready_o = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || result_o.ready;

  assign result_o.valid             = out_valid_q;
  assign result_o.readability_index = idx_q;
  assign result_o.grade_band        = band_q;
  assign result_o.grade_number      = number_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      snap_q      <= '0;
      prod_l_q    <= '0;
      prod_e_q    <= '0;
      prod_w_q    <= '0;
      bias_q      <= '0;
      den_q       <= '0;
      num_q       <= '0;
      neg_q       <= 1'b0;
      dvd_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      band_q      <= ric_pkg::BAND_BELOW;
      number_q    <= '0;
    end else begin
      // in the final state a free output register is refilled instead
      if (out_valid_q && result_o.ready && (state_q != ST_FIN)) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            snap_q  <= pop_data_i;
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          prod_l_q <= ric_pkg::PROD_L_W'(snap_q.letters) * ric_pkg::PROD_L_W'(ric_pkg::CoefLetter);
          prod_e_q <= ric_pkg::PROD_E_W'(snap_q.sentences)
                    * ric_pkg::PROD_E_W'(ric_pkg::CoefSentence);
          prod_w_q <= ric_pkg::PROD_W_W'(words) * ric_pkg::PROD_W_W'(ric_pkg::CoefWord);
          bias_q   <= ric_pkg::BIAS_W'(words) * ric_pkg::BIAS_W'(ric_pkg::BiasScale);
          den_q    <= ric_pkg::DIVR_W'(words) * ric_pkg::DIVR_W'(ric_pkg::DenScale);
          state_q  <= ST_SUM;
        end
        ST_SUM: begin
          num_q   <= num_d;
          neg_q   <= num_d[ric_pkg::NUM_W-1];
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          dvd_q   <= dvd_d;
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= ric_pkg::CNT_W'(ric_pkg::DIVD_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= fits ? diff[ric_pkg::DIVR_W-1:0] : trial[ric_pkg::DIVR_W-1:0];
          quo_q <= {quo_q[ric_pkg::DIVD_W-2:0], fits};
          dvd_q <= {dvd_q[ric_pkg::DIVD_W-2:0], 1'b0};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            idx_q       <= idx_d;
            band_q      <= band_d;
            number_q    <= number_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/readability_index_counter.sv
// readability_index_counter: top level of the coleman-liau readability index block
// depends on ric_pkg, ric_text_if, ric_result_if, ric_front, ric_queue and ric_back
//
// The block takes a text one byte per transfer on text_i and counts ASCII letters,
// spaces and sentence ends ('.', '?', '!') in saturating tallies of
// ric_pkg::TALLY_WIDTH bits. Words are spaces plus one. On the byte marked
// end_of_text (counted like any other) it hands the counts to a two-entry queue,
// clears the tallies and goes on counting the next text at one byte per cycle.
// The back part takes one snapshot at a time and returns on result_o the index
// round((588*L - 2960*S - 1580*W) / (100*W)), rounded half away from zero and
// clamped to [-2000000, 400000], with a grade band (0 below grade 1, 1 for grades
// 1 to 15 with grade_number holding the grade, 2 for grade 16 and up). Bytes
// stream in at one per cycle while the queue has room; the back part steps
// through its states scale, sum, prep, div and fin, with a restoring divider
// that makes one quotient bit per cycle. The input stalls only when two
// finished texts wait in the queue, on any byte; a finished result waits in an
// output register without holding up the divider for the next text.
`default_nettype none

module readability_index_counter (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ric_text_if.sink       text_i,
  ric_result_if.source   result_o
);

  // snapshot handoff from front to queue
  ric_pkg::snapshot_t push_data;
  logic               push_valid;
  logic               push_ready;

  // snapshot handoff from queue to back
  ric_pkg::snapshot_t pop_data;
  logic               pop_valid;
  logic               pop_ready;

  // front: classify bytes, keep the tallies
  ric_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // queue: decouples counting from the division
  ric_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  // back: scale, divide, round, clamp, grade
  ric_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .result_o    (result_o)
  );

  // a last byte that is taken always leaves a snapshot waiting for the back part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_i.valid && text_i.ready && text_i.end_of_text) |=> pop_valid)
    else $error("snapshot lost after last byte");

  // grade number is only used inside the numbered band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.grade_band != ric_pkg::BAND_GRADE))
      |-> (result_o.grade_number == 4'd0))
    else $error("grade number set outside numbered band");

  // a numbered grade equals the index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.grade_band == ric_pkg::BAND_GRADE))
      |-> (result_o.readability_index
           == ric_pkg::INDEX_W'(result_o.grade_number)))
    else $error("grade number does not match index");

  // the band never holds the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.grade_band != 2'd3))
    else $error("invalid grade band");

endmodule

`default_nettype wire

>>> bench/tb_readability_index_counter.sv
// tb_readability_index_counter: self-checking bench for the readability index counter
// depends on ric_pkg, ric_text_if, ric_result_if and the readability_index_counter top level
`timescale 1ns / 1ps

module tb_readability_index_counter;

  // no transfer on either side for this long means the block is stuck
  localparam int unsigned WatchdogLimit = 2000;
  // quiet cycles after the last result, well past one divider pass
  localparam int unsigned DrainCycles   = 100;
  // least number of input bytes sent by the random part; its last text is sent whole
  localparam int unsigned RandomItems   = 523;
  localparam int unsigned MaxShown      = 10;

  // letter ranges
  localparam logic [7:0] UpperA = 8'h41;
  localparam logic [7:0] UpperZ = 8'h5A;
  localparam logic [7:0] LowerA = 8'h61;
  localparam logic [7:0] LowerZ = 8'h7A;

  // one finished text as the block reports it
  typedef struct packed {
    logic signed [ric_pkg::INDEX_W-1:0] index;
    ric_pkg::band_e                     band;
    logic [3:0]                         grade;
  } grade_rec_t;

  // a row of the directed table; known rows carry the grade typed in by hand
  typedef struct packed {
    logic [7:0]                         ch;
    logic                               last;
    logic                               known;
    logic signed [ric_pkg::INDEX_W-1:0] index;
    ric_pkg::band_e                     band;
    logic [3:0]                         grade;
  } dir_row_t;

  localparam int unsigned DirCount = 27;
  localparam dir_row_t DirRows [DirCount] = '{
    // a lone space: two words, nothing else
    '{8'h20, 1'b1, 1'b1, -22'sd16, ric_pkg::BAND_BELOW,   4'd0},
    // letter range ends, four letters in one word
    '{UpperA, 1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{LowerZ, 1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{UpperZ, 1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{LowerA, 1'b1, 1'b1, 22'sd8,  ric_pkg::BAND_GRADE,   4'd8},
    // six letters among bytes just outside the letter ranges, zero and all-ones
    '{8'h40,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h62,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h5B,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h63,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h60,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h64,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h7B,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h65,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h00,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h66,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'hFF,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h67,  1'b1, 1'b1, 22'sd19, ric_pkg::BAND_COLLEGE, 4'd0},
    // five letters, one space, all three sentence ends: quotient lands on a half
    '{8'h61,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{8'h62,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{ric_pkg::CharSpace, 1'b0, 1'b0, 22'sd0, ric_pkg::BAND_BELOW, 4'd0},
    '{8'h63,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{ric_pkg::CharDot, 1'b0, 1'b0, 22'sd0, ric_pkg::BAND_BELOW, 4'd0},
    '{8'h64,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{ric_pkg::CharQuery, 1'b0, 1'b0, 22'sd0, ric_pkg::BAND_BELOW, 4'd0},
    '{8'h65,  1'b0, 1'b0, 22'sd0,  ric_pkg::BAND_BELOW,   4'd0},
    '{ric_pkg::CharBang, 1'b1, 1'b0, 22'sd0, ric_pkg::BAND_BELOW, 4'd0},
    // a lone full stop
    '{ric_pkg::CharDot, 1'b1, 1'b1, -22'sd45, ric_pkg::BAND_BELOW, 4'd0}
  };

  logic clk;
  logic rst_n;

  ric_text_if   text_if ();
  ric_result_if result_if ();

  readability_index_counter dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .text_i   (text_if),
    .result_o (result_if)
  );

  // predictor state: tallies of the text now streaming in
  ric_pkg::tally_t letter_cnt;
  ric_pkg::tally_t space_cnt;
  ric_pkg::tally_t end_cnt;

  // grades still owed by the block, oldest first
  grade_rec_t grade_q [$];

  int unsigned mismatches;
  bit          timed_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input longint want, input longint got);
    if (mismatches < MaxShown)
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    mismatches++;
  endtask

  // drive one byte after a gap, wait for its transfer, then update the predictor
  task automatic send_byte(input logic [7:0] ch, input logic last, input int unsigned gap);
    longint     words;
    longint     num;
    longint     den;
    longint     q;
    grade_rec_t rec;
    if (gap != 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= ch;
    text_if.end_of_text <= last;
    do @(posedge clk); while (!text_if.ready);

    // saturating tallies
    if ((ch >= UpperA && ch <= UpperZ) || (ch >= LowerA && ch <= LowerZ)) begin
      if (letter_cnt != ric_pkg::TallyMax) letter_cnt++;
    end else if (ch == ric_pkg::CharSpace) begin
      if (space_cnt != ric_pkg::TallyMax) space_cnt++;
    end else if (ch == ric_pkg::CharDot || ch == ric_pkg::CharQuery
                 || ch == ric_pkg::CharBang) begin
      if (end_cnt != ric_pkg::TallyMax) end_cnt++;
    end

    if (last) begin
      // index scaled by 100, divided by 100 * words, rounded half away from zero
      words = longint'(space_cnt) + 1;
      num   = longint'(ric_pkg::CoefLetter) * longint'(letter_cnt)
              - longint'(ric_pkg::CoefSentence) * longint'(end_cnt)
              - longint'(ric_pkg::CoefWord) * words;
      den   = 100 * words;
      if (num >= 0)
        q = (2 * num + den) / (2 * den);
      else
        q = -((2 * (-num) + den) / (2 * den));
      if (q < -longint'(ric_pkg::IndexLowMag)) q = -longint'(ric_pkg::IndexLowMag);
      if (q > longint'(ric_pkg::IndexHigh))    q = longint'(ric_pkg::IndexHigh);

      rec.index = q[ric_pkg::INDEX_W-1:0];
      if (q < 1) begin
        rec.band  = ric_pkg::BAND_BELOW;
        rec.grade = 4'd0;
      end else if (q >= longint'(ric_pkg::GradeTop)) begin
        rec.band  = ric_pkg::BAND_COLLEGE;
        rec.grade = 4'd0;
      end else begin
        rec.band  = ric_pkg::BAND_GRADE;
        rec.grade = q[3:0];
      end
      grade_q.push_back(rec);

      letter_cnt = '0;
      space_cnt  = '0;
      end_cnt    = '0;
    end
  endtask

  // result side: random stalls before results, with calm stretches now and then
  initial begin : result_sink
    int unsigned stall;
    bit          steady;
    steady = 1'b0;
    result_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      if ($urandom_range(0, 7) == 0) steady = !steady;
    end
  end

  // compare every result transfer with the oldest grade owed
  always @(posedge clk) begin : check_result
    grade_rec_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (grade_q.size() == 0) begin
        note_mismatch("result with nothing owed, index", 0,
                      longint'(result_if.readability_index));
      end else begin
        want = grade_q.pop_front();
        if (result_if.readability_index !== want.index)
          note_mismatch("readability_index", longint'(want.index),
                        longint'(result_if.readability_index));
        if (result_if.grade_band !== want.band)
          note_mismatch("grade_band", longint'(want.band), longint'(result_if.grade_band));
        if (result_if.grade_number !== want.grade)
          note_mismatch("grade_number", longint'(want.grade),
                        longint'(result_if.grade_number));
      end
    end
  end

  initial begin : stimulus
    int unsigned idle;
    int unsigned counted;
    int unsigned len;
    int unsigned pick;
    bit          burst;
    logic [7:0]  ch;

    letter_cnt = '0;
    space_cnt  = '0;
    end_cnt    = '0;
    mismatches = 0;
    timed_out  = 1'b0;

    rst_n               <= 1'b0;
    text_if.valid       <= 1'b0;
    text_if.text_byte   <= 8'h00;
    text_if.end_of_text <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fork
      begin
        // directed table; hand-typed grades replace the predicted one
        for (int r = 0; r < DirCount; r++) begin
          send_byte(DirRows[r].ch, DirRows[r].last, $urandom_range(0, 19));
          if (DirRows[r].known)
            grade_q[$] = '{DirRows[r].index, DirRows[r].band, DirRows[r].grade};
        end

        // random texts, mostly short, a few long, with a mix of byte kinds
        counted = 0;
        while (counted < RandomItems) begin
          burst = ($urandom_range(0, 3) == 0);
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 25);
          for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
              ch = ($urandom_range(0, 1) ? LowerA : UpperA) + 8'($urandom_range(0, 25));
            else if (pick < 65)
              ch = ric_pkg::CharSpace;
            else if (pick < 75)
              ch = ($urandom_range(0, 2) == 0) ? ric_pkg::CharDot
                 : ($urandom_range(0, 1) == 0) ? ric_pkg::CharQuery : ric_pkg::CharBang;
            else if (pick < 90)
              ch = 8'($urandom_range(0, 127));
            else
              ch = 8'($urandom_range(0, 255));
            counted++;
            send_byte(ch, i == len - 1, burst ? 0 : $urandom_range(0, 19));
          end
        end
        text_if.valid <= 1'b0;

        // let every owed grade arrive, then watch for strays
        while (grade_q.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
      end
      begin
        // watchdog: counts cycles without a transfer on either side
        idle = 0;
        while (idle < WatchdogLimit) begin
          @(posedge clk);
          if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready))
            idle = 0;
          else
            idle++;
        end
        timed_out = 1'b1;
        $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      end
    join_any

    if (grade_q.size() != 0)
      $display("%0d grades never arrived", grade_q.size());
    if (!timed_out && mismatches == 0 && grade_q.size() == 0)
      $display("PASS readability_index_counter");
    else
      $display("FAIL readability_index_counter");
    $finish;
  end

endmodule

>>> sim.f
design/ric_pkg.sv
design/ric_text_if.sv
design/ric_result_if.sv
design/ric_front.sv
design/ric_queue.sv
design/ric_back.sv
design/readability_index_counter.sv
bench/tb_readability_index_counter.sv
